// ===== rtl/pltw_pkg.sv =====
// Package for the piecewise-linear time warp unit: sizes, codes and sequencer states.
package pltw_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int TIME_W     = 32;
  localparam int DIV_CNT_W  = $clog2(TIME_W);
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 40;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Word index of the register: paddr[2]
  localparam logic REG_POINT_COUNT = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRIME0,
    S_PRIME1,
    S_SCAN,
    S_REF0,
    S_REF1,
    S_SETUP,
    S_MUL,
    S_DIV,
    S_FIN,
    S_DONE
  } pltw_state_t;

endpackage

// ===== rtl/piecewise_linear_time_warp_unit.sv =====
// Piecewise-linear time warp unit: breakpoint tables, segment scan and serial divider.
//
// Write words (tuser = 0) store one breakpoint pair and give no result. A query
// word (tuser = 1) is scanned against the target table one entry per cycle
// through the table's read port, from segment 0 up to the segment that holds
// it; the interpolation then reads the two reference points, forms the product
// and runs the restoring divider that retires one quotient bit per cycle.
// point_count is capped at 64; a query with fewer than two points, or one that
// lands in no segment, is a miss with a zero result. A finished result waits
// while the output register holds a word that is not taken.
// in_tready is low while a query is at work; a finished result waits in the
// output register while new words are taken.
module piecewise_linear_time_warp_unit
  import pltw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // point_index[5:0], ref_time[37:6], target_time[69:38], query_time[101:70], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // operation[0]
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // warped_time[31:0], segment_index[37:32], zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  // found[0]
  output logic                  out_tuser,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [TIME_W-1:0] ref_mem [MAX_POINTS];
  logic [TIME_W-1:0] tgt_mem [MAX_POINTS];

  pltw_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]     point_count_r;
  logic [CNT_W-1:0]     n_r, n_nxt;
  logic [TIME_W-1:0]    t_r, t_nxt;
  logic [IDX_W-1:0]     seg_r, seg_nxt;
  logic [TIME_W-1:0]    lo_r, lo_nxt;
  logic [TIME_W-1:0]    tgt_q_r, ref_q_r;
  logic [TIME_W-1:0]    r0_r, r0_nxt;
  logic [TIME_W-1:0]    dt_r, dt_nxt;
  logic [TIME_W-1:0]    span_r, span_nxt;
  logic [TIME_W-1:0]    mag_r, mag_nxt;
  logic                 neg_r, neg_nxt;
  logic [TIME_W-1:0]    rem_r, rem_nxt;
  logic [TIME_W-1:0]    sh_r, sh_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [TIME_W-1:0]    res_time_r, res_time_nxt;
  logic [IDX_W-1:0]     res_seg_r, res_seg_nxt;
  logic                 res_found_r, res_found_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [TIME_W-1:0]    out_time_r, out_time_nxt;
  logic [IDX_W-1:0]     out_seg_r, out_seg_nxt;
  logic                 out_found_r, out_found_nxt;

  logic [IDX_W-1:0]     tgt_addr, ref_addr;
  logic                 in_acc, cfg_wr;
  logic [IDX_W-1:0]     in_idx;
  logic [TIME_W-1:0]    in_ref, in_tgt, in_query;
  logic [2*TIME_W-1:0]  prod;
  logic [TIME_W:0]      div_trial, div_diff, sum;
  logic                 hit;

  assign in_idx   = in_tdata[IDX_W-1:0];
  assign in_ref   = in_tdata[IDX_W +: TIME_W];
  assign in_tgt   = in_tdata[IDX_W+TIME_W +: TIME_W];
  assign in_query = in_tdata[IDX_W+2*TIME_W +: TIME_W];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready &
                      (cfg_paddr[2] == REG_POINT_COUNT);
  assign cfg_prdata = (cfg_paddr[2] == REG_POINT_COUNT) ?
                      {{(CFG_DATA_W-CNT_W){1'b0}}, point_count_r} : '0;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-TIME_W-IDX_W){1'b0}}, out_seg_r, out_time_r};
  assign out_tuser  = out_found_r;

  assign prod      = {{TIME_W{1'b0}}, dt_r} * {{TIME_W{1'b0}}, mag_r};
  assign div_trial = {rem_r, sh_r[TIME_W-1]};
  assign div_diff  = div_trial - {1'b0, span_r};
  assign sum       = {1'b0, r0_r} + {1'b0, sh_r};
  assign hit       = (t_r >= lo_r) && (t_r < tgt_q_r);

  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser == OP_WRITE)) begin
      ref_mem[in_idx] <= in_ref;
      tgt_mem[in_idx] <= in_tgt;
    end
    tgt_q_r <= tgt_mem[tgt_addr];
    ref_q_r <= ref_mem[ref_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      point_count_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        point_count_r <= cfg_pwdata[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    t_r         <= t_nxt;
    seg_r       <= seg_nxt;
    lo_r        <= lo_nxt;
    r0_r        <= r0_nxt;
    dt_r        <= dt_nxt;
    span_r      <= span_nxt;
    mag_r       <= mag_nxt;
    neg_r       <= neg_nxt;
    rem_r       <= rem_nxt;
    sh_r        <= sh_nxt;
    cnt_r       <= cnt_nxt;
    res_time_r  <= res_time_nxt;
    res_seg_r   <= res_seg_nxt;
    res_found_r <= res_found_nxt;
    out_time_r  <= out_time_nxt;
    out_seg_r   <= out_seg_nxt;
    out_found_r <= out_found_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    t_nxt         = t_r;
    seg_nxt       = seg_r;
    lo_nxt        = lo_r;
    r0_nxt        = r0_r;
    dt_nxt        = dt_r;
    span_nxt      = span_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    rem_nxt       = rem_r;
    sh_nxt        = sh_r;
    cnt_nxt       = cnt_r;
    res_time_nxt  = res_time_r;
    res_seg_nxt   = res_seg_r;
    res_found_nxt = res_found_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_time_nxt  = out_time_r;
    out_seg_nxt   = out_seg_r;
    out_found_nxt = out_found_r;
    tgt_addr      = seg_r + IDX_W'(2);
    ref_addr      = seg_r + IDX_W'(1);

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser == OP_QUERY)) begin
          t_nxt   = in_query;
          seg_nxt = '0;
          n_nxt   = (point_count_r > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                         : point_count_r;
          if (n_nxt < CNT_W'(2)) begin
            res_time_nxt  = '0;
            res_seg_nxt   = '0;
            res_found_nxt = 1'b0;
            state_nxt     = S_DONE;
          end else begin
            state_nxt = S_PRIME0;
          end
        end
      end
      S_PRIME0: begin
        tgt_addr  = '0;
        state_nxt = S_PRIME1;
      end
      S_PRIME1: begin
        tgt_addr  = IDX_W'(1);
        lo_nxt    = tgt_q_r;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        // lo_r = target[seg], tgt_q_r = target[seg+1]
        if (hit) begin
          dt_nxt    = t_r - lo_r;
          span_nxt  = tgt_q_r - lo_r;
          state_nxt = S_REF0;
        end else if (({1'b0, seg_r} + CNT_W'(2)) >= n_r) begin
          res_time_nxt  = '0;
          res_seg_nxt   = '0;
          res_found_nxt = 1'b0;
          state_nxt     = S_DONE;
        end else begin
          lo_nxt  = tgt_q_r;
          seg_nxt = seg_r + IDX_W'(1);
        end
      end
      S_REF0: begin
        ref_addr  = seg_r;
        state_nxt = S_REF1;
      end
      S_REF1: begin
        r0_nxt    = ref_q_r;
        state_nxt = S_SETUP;
      end
      S_SETUP: begin
        neg_nxt   = ref_q_r < r0_r;
        mag_nxt   = (ref_q_r < r0_r) ? (r0_r - ref_q_r) : (ref_q_r - r0_r);
        state_nxt = S_MUL;
      end
      S_MUL: begin
        // dt < span keeps the high half below the divisor
        rem_nxt   = prod[2*TIME_W-1:TIME_W];
        sh_nxt    = prod[TIME_W-1:0];
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (!div_diff[TIME_W]) begin
          rem_nxt = div_diff[TIME_W-1:0];
          sh_nxt  = {sh_r[TIME_W-2:0], 1'b1};
        end else begin
          rem_nxt = div_trial[TIME_W-1:0];
          sh_nxt  = {sh_r[TIME_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == {DIV_CNT_W{1'b1}}) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (neg_r) begin
          res_time_nxt = (sh_r > r0_r) ? '0 : (r0_r - sh_r);
        end else begin
          res_time_nxt = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
        end
        res_seg_nxt   = seg_r;
        res_found_nxt = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_time_nxt  = res_time_r;
          out_seg_nxt   = res_seg_r;
          out_found_nxt = res_found_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss result carries nonzero data");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> ({1'b0, seg_r} + CNT_W'(2)) <= n_r)
    else $error("scan ran past last segment");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r < span_r)
    else $error("divider remainder not below divisor");

  a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> state_r == S_PRIME0 || state_r == S_DONE)
    else $error("query did not start the sequencer");

endmodule

// ===== tb/sv/piecewise_linear_time_warp_unit_tb.sv =====
// Testbench for the piecewise-linear time warp unit: directed table, random table builds, scoreboard.
module piecewise_linear_time_warp_unit_tb
  import pltw_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] warped;
    logic [5:0]  seg;
    logic        found;
  } warp_res_t;

  typedef enum {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic        op;
    logic [5:0]  idx;
    logic [31:0] rt;
    logic [31:0] tt;
    logic [31:0] qt;
    bit          typed;
    warp_res_t   res;
  } row_t;

  localparam logic [CFG_ADDR_W-1:0] ADDR_POINT_COUNT = {REG_POINT_COUNT, 2'b00};
  localparam int HOLD_CYCLES = 1500;
  localparam int SETTLE_CYCLES = 150;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // predictor state
  logic [31:0] bp_ref [MAX_POINTS];
  logic [31:0] bp_tgt [MAX_POINTS];
  logic [6:0]  point_cnt;

  // current random table
  logic [31:0] seg_ref [MAX_POINTS];
  logic [31:0] seg_tgt [MAX_POINTS];
  int          seg_n;

  warp_res_t pending_warps[$];
  row_t      plan[$];
  int        bad_count;
  int        words_sent;
  int        send_pct;
  int        recv_pct;
  bit        want_hold;
  int        hold_left;

  piecewise_linear_time_warp_unit u_top (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic warp_res_t warp_lookup(input logic [31:0] t);
    warp_res_t   r;
    int          n;
    logic [31:0] a, b, r0, r1;
    logic [63:0] dt, span, mag, q;
    r = '0;
    n = (point_cnt > MAX_POINTS) ? MAX_POINTS : int'(point_cnt);
    for (int i = 0; i + 1 < n; i++) begin
      a = bp_tgt[i];
      b = bp_tgt[i+1];
      if (t >= a && t < b) begin
        r0   = bp_ref[i];
        r1   = bp_ref[i+1];
        dt   = {32'b0, t - a};
        span = {32'b0, b - a};
        mag  = (r1 < r0) ? {32'b0, r0 - r1} : {32'b0, r1 - r0};
        if (span == 0) begin
          r.warped = r0;
        end else begin
          q = dt * mag / span;
          if (r1 < r0) r.warped = (q > {32'b0, r0}) ? 32'd0 : r0 - q[31:0];
          else r.warped = ({32'b0, r0} + q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r0 + q[31:0];
        end
        r.seg   = 6'(i);
        r.found = 1'b1;
        return r;
      end
    end
    return r;
  endfunction

  function automatic row_t wr(input logic [5:0] idx, input logic [31:0] rt, tt);
    return '{ROW_WORD, OP_WRITE, idx, rt, tt, 32'hFFFF_FFFF, 1'b0, '0};
  endfunction

  function automatic row_t qy(input logic [31:0] t);
    return '{ROW_WORD, OP_QUERY, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, t, 1'b0, '0};
  endfunction

  function automatic row_t qx(input logic [31:0] t, input logic [31:0] w,
                              input logic [5:0] s, input logic f);
    return '{ROW_WORD, OP_QUERY, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, t, 1'b1, {w, s, f}};
  endfunction

  function automatic row_t cf(input logic [31:0] v);
    return '{ROW_CFG, OP_WRITE, 6'd0, v, 32'd0, 32'd0, 1'b0, '0};
  endfunction

  task automatic add_row(input row_t rw);
    plan.insert(plan.size(), rw);
  endtask

  task automatic note_bad(input string msg);
    bad_count++;
    if (bad_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic push_word(input logic op, input logic [5:0] idx, input logic [31:0] rt, tt, qt,
                           input bit typed, input warp_res_t tres);
    warp_res_t r;
    while ($urandom_range(99) < send_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, qt, tt, rt, idx};
    do @(posedge clk); while (!in_tready);
    words_sent++;
    if (op == OP_WRITE) begin
      bp_ref[idx] = rt;
      bp_tgt[idx] = tt;
    end else begin
      r = warp_lookup(qt);
      if (typed) r = tres;
      pending_warps.insert(pending_warps.size(), r);
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_warps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write point_count, then read it back
  task automatic cfg_write(input logic [31:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_POINT_COUNT;
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    point_cnt = v[6:0];
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {25'b0, point_cnt})
      note_bad($sformatf("point_count read exp %0h got %0h", point_cnt, cfg_prdata));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic build_table(input int n);
    logic [31:0] cur, step_max, stp, base;
    int          rmode;
    bit          down;
    cur      = ($urandom_range(3) == 0) ? 32'd0 : $urandom_range(32'h4000_0000);
    step_max = (32'hFFFF_FFFF - cur) / ((n > 0) ? n : 1);
    rmode    = $urandom_range(3);
    base     = $urandom;
    for (int i = 0; i < n; i++) begin
      seg_tgt[i] = cur;
      case ($urandom_range(9))
        0:          stp = 32'd0;
        1, 2, 3, 4: stp = $urandom_range(32'h0004_0000, 1);
        default:    stp = $urandom_range(step_max, 1);
      endcase
      cur = cur + stp;
      case (rmode)
        0: seg_ref[i] = $urandom;
        1: seg_ref[i] = (i == 0) ? $urandom_range(32'h1000_0000)
                                 : seg_ref[i-1] + $urandom_range(32'h0400_0000);
        2: seg_ref[i] = (i == 0) ? 32'hFFFF_FFFF - $urandom_range(32'h1000_0000)
                                 : seg_ref[i-1] - $urandom_range(32'h0400_0000);
        default: seg_ref[i] = base;
      endcase
    end
    if (n >= 2 && $urandom_range(3) == 0) seg_tgt[n-1] = 32'hFFFF_FFFF;
    seg_n = n;
    down  = $urandom_range(1);
    for (int i = 0; i < n; i++) begin
      int k;
      k = down ? n - 1 - i : i;
      push_word(OP_WRITE, 6'(k), seg_ref[k], seg_tgt[k], $urandom, 1'b0, '0);
    end
  endtask

  task automatic run_queries(input int nq);
    logic [31:0] t, lo, hi;
    int          j, idx;
    for (int k = 0; k < nq; k++) begin
      if ($urandom_range(9) == 0) begin
        idx = $urandom_range(MAX_POINTS - 1);
        if (idx < seg_n)
          push_word(OP_WRITE, 6'(idx), seg_ref[idx], seg_tgt[idx], $urandom, 1'b0, '0);
        else
          push_word(OP_WRITE, 6'(idx), $urandom, $urandom, $urandom, 1'b0, '0);
      end else begin
        if (seg_n >= 2 && $urandom_range(9) < 8) begin
          j  = $urandom_range(seg_n - 2);
          lo = seg_tgt[j];
          hi = seg_tgt[j+1];
          if (hi > lo) begin
            case ($urandom_range(3))
              0:       t = lo;
              1:       t = hi - 1;
              default: t = $urandom_range(hi - 1, lo);
            endcase
          end else begin
            t = lo;
          end
        end else begin
          case ($urandom_range(3))
            0:       t = 32'd0;
            1:       t = 32'hFFFF_FFFF;
            default: t = $urandom;
          endcase
        end
        push_word(OP_QUERY, 6'($urandom), $urandom, $urandom, t, 1'b0, '0);
      end
    end
  endtask

  task automatic run_phase(input int goal, input bit fill_first);
    int          start, n, r;
    logic [31:0] v;
    start = words_sent;
    while (words_sent - start < goal) begin
      settle();
      r = $urandom_range(99);
      if (fill_first) n = MAX_POINTS;
      else if (r < 5) n = 0;
      else if (r < 10) n = 1;
      else if (r < 20) n = MAX_POINTS;
      else if (r < 80) n = $urandom_range(8, 2);
      else n = $urandom_range(20, 9);
      fill_first = 1'b0;
      build_table(n);
      settle();
      v = (n == MAX_POINTS && $urandom_range(1)) ? 32'd127 : 32'(n);
      if ($urandom_range(3) == 0) v[31:7] = 25'($urandom);
      cfg_write(v);
      run_queries($urandom_range(30, 8));
    end
  endtask

  // result side: checking, stalls and the long hold-off
  always @(posedge clk) begin : result_side
    warp_res_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_warps.size() == 0) begin
        note_bad($sformatf("unexpected word %0h found %0b", out_tdata, out_tuser));
      end else begin
        exp_r = pending_warps.pop_front();
        if (out_tdata[31:0] !== exp_r.warped || out_tdata[37:32] !== exp_r.seg ||
            out_tuser !== exp_r.found)
          note_bad($sformatf("warp exp t=%0h seg=%0d f=%0b got t=%0h seg=%0d f=%0b",
                             exp_r.warped, exp_r.seg, exp_r.found,
                             out_tdata[31:0], out_tdata[37:32], out_tuser));
      end
    end
    if (want_hold) begin
      hold_left = HOLD_CYCLES;
      want_hold = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_pct);
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= OP_WRITE;
    out_tready  <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    bad_count = 0;
    words_sent = 0;
    send_pct = 0;
    recv_pct = 0;
    want_hold = 1'b0;
    hold_left = 0;
    point_cnt = '0;
    seg_n = 0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      bp_ref[i] = '0;
      bp_tgt[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(qx(32'd0, 32'd0, 6'd0, 1'b0));
    add_row(wr(6'd0, 32'd0, 32'd0));
    add_row(wr(6'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    add_row(cf(32'd1));
    add_row(qx(32'd0, 32'd0, 6'd0, 1'b0));
    add_row(cf(32'd2));
    add_row(qx(32'd0, 32'd0, 6'd0, 1'b1));
    add_row(qx(32'hFFFF_FFFE, 32'hFFFF_FFFE, 6'd0, 1'b1));
    add_row(qx(32'hFFFF_FFFF, 32'd0, 6'd0, 1'b0));
    // falling reference times
    add_row(wr(6'd0, 32'hFFFF_FFFF, 32'd0));
    add_row(wr(6'd1, 32'd0, 32'hFFFF_FFFF));
    add_row(qx(32'hFFFF_FFFE, 32'd1, 6'd0, 1'b1));
    add_row(qx(32'd0, 32'hFFFF_FFFF, 6'd0, 1'b1));
    // backward segment
    add_row(wr(6'd2, 32'h0003_0000, 32'hFFFF_FFFF));
    add_row(wr(6'd3, 32'h1234_5678, 32'h8000_0000));
    add_row(wr(6'd0, 32'h0001_0000, 32'd0));
    add_row(wr(6'd1, 32'h0002_0000, 32'h0001_0000));
    add_row(cf(32'd4));
    add_row(qy(32'h0000_8000));
    add_row(qy(32'h9000_0000));
    add_row(qy(32'hFFFF_FFFF));
    add_row(qy(32'h0001_0000));
    add_row(wr(6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    add_row(cf(32'd0));
    add_row(qx(32'h0000_1234, 32'd0, 6'd0, 1'b0));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        cfg_write(plan[i].rt);
      end else begin
        push_word(plan[i].op, plan[i].idx, plan[i].rt, plan[i].tt, plan[i].qt,
                  plan[i].typed, plan[i].res);
      end
    end

    send_pct = 0;  recv_pct = 0;
    run_phase(150, 1'b1);
    send_pct = 55; recv_pct = 0;
    run_phase(130, 1'b0);
    send_pct = 0;  recv_pct = 55;
    run_phase(130, 1'b0);
    send_pct = 7;  recv_pct = 7;
    run_phase(130, 1'b0);
    settle();
    send_pct = 0;  recv_pct = 0;
    want_hold = 1'b1;
    run_phase(80, 1'b0);

    in_tvalid <= 1'b0;
    for (int k = 0; k < 20000 && pending_warps.size() != 0; k++) @(posedge clk);
    if (pending_warps.size() != 0)
      note_bad($sformatf("%0d warp results never arrived", pending_warps.size()));
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bad_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pltw_pkg.sv
rtl/piecewise_linear_time_warp_unit.sv
tb/sv/piecewise_linear_time_warp_unit_tb.sv
